@@ sv/brf_pkg.sv @@
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and constants for the byte ring FIFO with skip.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int Depth  = 1024;
  localparam int AddrW  = $clog2(Depth);
  localparam int SizeW  = $clog2(Depth + 1);
  localparam int ByteW  = 8;
  localparam int OvfW   = 16;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_SKIP  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef struct packed {
    op_t              operation;
    logic [ByteW-1:0] push_byte;
    logic [SizeW-1:0] skip_count;
  } item_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [ByteW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic             popped;
    logic             empty_flag;
    logic             rejected;
    logic [SizeW-1:0] occupancy;
    logic [OvfW-1:0]  overflow_count;
  } result_t;

endpackage

@@ sv/brf_ram.sv @@
// ----------------------------------------------------------------------------
// brf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/brf_ctrl.sv @@
// ----------------------------------------------------------------------------
// brf_ctrl
// Ring pointers, free slot count, size and drop counter; decodes one request
// per cycle, when fire is high, into a storage access and a result.
// ----------------------------------------------------------------------------
module brf_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [brf_pkg::SizeW-1:0] cfg_data,
  input  logic                     fire,
  input  brf_pkg::item_t           item,
  output brf_pkg::ram_req_t        ram_req,
  output brf_pkg::result_t         result
);
  import brf_pkg::*;

  logic [SizeW-1:0] size;
  logic [AddrW-1:0] read_index;
  logic [AddrW-1:0] write_index;
  logic [SizeW-1:0] free_slots;
  logic [OvfW-1:0]  dropped_count;

  logic [AddrW-1:0] read_index_next;
  logic [AddrW-1:0] write_index_next;
  logic [SizeW-1:0] free_slots_next;
  logic [OvfW-1:0]  dropped_count_next;
  logic [SizeW-1:0] size_next;

  logic [SizeW-1:0] occ;
  logic [SizeW:0]   wi_inc;
  logic [SizeW:0]   ri_inc;
  logic [SizeW:0]   skip_sum;

  assign occ      = size - free_slots;
  assign wi_inc   = (SizeW+1)'(write_index) + (SizeW+1)'(1);
  assign ri_inc   = (SizeW+1)'(read_index) + (SizeW+1)'(1);
  assign skip_sum = (SizeW+1)'(read_index) + (SizeW+1)'(item.skip_count);

  always_comb begin
    if (cfg_data == '0) begin
      size_next = SizeW'(1);
    end else if (cfg_data > SizeW'(Depth)) begin
      size_next = SizeW'(Depth);
    end else begin
      size_next = cfg_data;
    end
  end

  always_comb begin
    read_index_next    = read_index;
    write_index_next   = write_index;
    free_slots_next    = free_slots;
    dropped_count_next = dropped_count;
    ram_req            = '0;
    ram_req.waddr      = write_index;
    ram_req.wdata      = item.push_byte;
    ram_req.raddr      = read_index;
    result             = '0;
    unique case (item.operation)
      OP_PUSH: begin
        if (free_slots != '0) begin
          ram_req.we       = 1'b1;
          free_slots_next  = free_slots - SizeW'(1);
          write_index_next = (wi_inc >= (SizeW+1)'(size)) ? '0 : AddrW'(wi_inc);
        end else begin
          dropped_count_next = dropped_count + OvfW'(1);
          result.rejected    = 1'b1;
        end
      end
      OP_POP: begin
        if (occ == '0) begin
          result.empty_flag = 1'b1;
        end else begin
          ram_req.re      = 1'b1;
          result.popped   = 1'b1;
          free_slots_next = free_slots + SizeW'(1);
          read_index_next = (ri_inc >= (SizeW+1)'(size)) ? '0 : AddrW'(ri_inc);
        end
      end
      OP_SKIP: begin
        if (item.skip_count > occ) begin
          result.rejected = 1'b1;
        end else begin
          free_slots_next = free_slots + item.skip_count;
          read_index_next = (skip_sum >= (SizeW+1)'(size))
                          ? AddrW'(skip_sum - (SizeW+1)'(size))
                          : AddrW'(skip_sum);
        end
      end
      OP_CLEAR: begin
        read_index_next  = '0;
        write_index_next = '0;
        free_slots_next  = size;
      end
      default: begin
      end
    endcase
    result.occupancy      = size - free_slots_next;
    result.overflow_count = dropped_count_next;
    if (!fire) begin
      ram_req.we = 1'b0;
      ram_req.re = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size          <= SizeW'(Depth);
      read_index    <= '0;
      write_index   <= '0;
      free_slots    <= SizeW'(Depth);
      dropped_count <= '0;
    end else if (cfg_we) begin
      size        <= size_next;
      read_index  <= '0;
      write_index <= '0;
      free_slots  <= size_next;
    end else if (fire) begin
      read_index    <= read_index_next;
      write_index   <= write_index_next;
      free_slots    <= free_slots_next;
      dropped_count <= dropped_count_next;
    end
  end

  a_free_le_size: assert property (@(posedge clk) disable iff (rst)
    free_slots <= size)
    else $error("free slot count above ring size");

  a_ptrs_in_ring: assert property (@(posedge clk) disable iff (rst)
    (SizeW'(read_index) < size) && (SizeW'(write_index) < size))
    else $error("ring pointer outside ring");

  a_drop_only_full: assert property (@(posedge clk) disable iff (rst)
    fire && !cfg_we && (dropped_count_next != dropped_count)
      |-> (free_slots == '0) && (item.operation == OP_PUSH))
    else $error("drop counted while ring not full");

  a_ptrs_track_occ: assert property (@(posedge clk) disable iff (rst)
    (free_slots != '0) && (free_slots != size)
      |-> ((write_index >= read_index)
           ? (SizeW'(write_index - read_index) == occ)
           : (SizeW'(write_index) + size - SizeW'(read_index) == occ)))
    else $error("pointers disagree with occupancy");

endmodule

@@ sv/byte_ring_fifo_with_skip_top.sv @@
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_skip_top
// Byte ring FIFO with configurable usable depth, pop, skip and clear.
//
//   channel  handshake                  payload
//   in       in_valid / in_stall        operation, push_byte, skip_count
//   out      out_valid / out_stall      pop_byte, empty_flag, rejected,
//                                       occupancy, overflow_count
//   cfg      cfg_valid / cfg_ready      cfg_data (buffer_size)
//
// One request per cycle unless the result is stalled; a taken request passes the
// input register, then the ring update and storage read into the result
// register. Storage is one 1024x8 RAM with a registered read port.
// Reset: ring empty, size 1024, drop counter zero; no clearing pass.
// A stalled result holds; one more request is buffered in the input register.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_skip_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                operation,
  input  logic [7:0]                push_byte,
  input  logic [10:0]               skip_count,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                pop_byte,
  output logic                      empty_flag,
  output logic                      rejected,
  output logic [10:0]               occupancy,
  output logic [15:0]               overflow_count,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [10:0]               cfg_data
);
  import brf_pkg::*;

  logic             in_full;
  item_t            in_item;
  logic             advance;
  ram_req_t         ram_req;
  result_t          result;
  result_t          res_q;
  logic [ByteW-1:0] ram_rdata;

  assign advance   = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && !advance;
  assign cfg_ready = !in_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item.operation  <= op_t'(operation);
      in_item.push_byte  <= push_byte;
      in_item.skip_count <= SizeW'(skip_count);
    end
  end

  brf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (SizeW'(cfg_data)),
    .fire     (advance),
    .item     (in_item),
    .ram_req  (ram_req),
    .result   (result)
  );

  brf_ram #(
    .WIDTH (ByteW),
    .DEPTH (Depth)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= result;
    end
  end

  assign pop_byte       = res_q.popped ? ram_rdata : '0;
  assign empty_flag     = res_q.empty_flag;
  assign rejected       = res_q.rejected;
  assign occupancy      = 11'(res_q.occupancy);
  assign overflow_count = res_q.overflow_count;

  a_no_empty_and_rej: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(empty_flag && rejected))
    else $error("empty and rejected reported together");

  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && res_q.popped |-> !empty_flag && !rejected)
    else $error("pop result flagged as failed");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

endmodule
